@@ src/pwn_pkg.sv @@
// Shared types and codes for the polygon winding-number query block.
// No dependencies; imported by pwn_edge, the top level and the testbench.
`timescale 1ns / 1ps

package pwn_pkg;

  // Action codes carried on the input tuser.
  localparam logic [1:0] ACT_CLEAR     = 2'd0;
  localparam logic [1:0] ACT_APPEND    = 2'd1;
  localparam logic [1:0] ACT_QUERY     = 2'd2;
  localparam logic [1:0] ACT_QUERY_ALT = 2'd3;

  // Status codes carried on the output tuser.
  localparam logic [1:0] STAT_STORED  = 2'd0;
  localparam logic [1:0] STAT_DROPPED = 2'd1;
  localparam logic [1:0] STAT_CLEARED = 2'd2;
  localparam logic [1:0] STAT_ANSWER  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_WALK   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } pwn_state_t;

  // Control from the sequencer to the edge pipeline.
  typedef struct packed {
    logic acc_clr;
    logic valid;
    logic is_edge;
  } edge_ctl_t;

endpackage

@@ src/pwn_vstore.sv @@
// Vertex store: one write port, one read port with registered read data.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module pwn_vstore #(
  parameter int COORD_BITS   = 24,
  parameter int MAX_VERTICES = 64
) (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [$clog2(MAX_VERTICES)-1:0] wr_addr,
  input  logic signed [COORD_BITS-1:0]    wr_x,
  input  logic signed [COORD_BITS-1:0]    wr_y,
  input  logic                            rd_en,
  input  logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
  output logic signed [COORD_BITS-1:0]    rd_x,
  output logic signed [COORD_BITS-1:0]    rd_y
);

  logic [2*COORD_BITS-1:0] mem [MAX_VERTICES];
  logic [2*COORD_BITS-1:0] rd_word;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_y, wr_x};
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  assign rd_x = rd_word[COORD_BITS-1:0];
  assign rd_y = rd_word[2*COORD_BITS-1:COORD_BITS];

endmodule

@@ src/pwn_edge.sv @@
// Edge pipeline: difference, cross-product and accumulate stages, one edge per cycle.
// Depends on pwn_pkg for the control struct.
`timescale 1ns / 1ps

module pwn_edge
  import pwn_pkg::*;
#(
  parameter int COORD_BITS   = 24,
  parameter int MAX_VERTICES = 64
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  edge_ctl_t                                ctl,
  input  logic signed [COORD_BITS-1:0]             qx,
  input  logic signed [COORD_BITS-1:0]             qy,
  input  logic signed [COORD_BITS-1:0]             rd_x,
  input  logic signed [COORD_BITS-1:0]             rd_y,
  output logic signed [$clog2(MAX_VERTICES)+2:0]   half_sum,
  output logic signed [$clog2(MAX_VERTICES)+2:0]   quarter_sum
);

  localparam int DW     = COORD_BITS + 1;
  localparam int PW     = 2 * DW;
  localparam int ACC_W  = $clog2(MAX_VERTICES) + 3;

  // previous vertex (start of the current edge)
  logic signed [COORD_BITS-1:0] x1, y1;

  logic signed [DW-1:0] x1e, y1e, x2e, y2e, qxe, qye;
  logic                 up_a, up_b, dn_a, dn_b;

  logic                 d_valid;
  logic signed [DW-1:0] d_dx, d_dyq, d_dy, d_dxq;
  logic [1:0]           d_up, d_dn;

  logic                 m_valid;
  logic signed [PW-1:0] m_p1, m_p2;
  logic [1:0]           m_up, m_dn;

  logic [ACC_W-1:0]     up_ext, dn_ext;

  assign x1e = {x1[COORD_BITS-1], x1};
  assign y1e = {y1[COORD_BITS-1], y1};
  assign x2e = {rd_x[COORD_BITS-1], rd_x};
  assign y2e = {rd_y[COORD_BITS-1], rd_y};
  assign qxe = {qx[COORD_BITS-1], qx};
  assign qye = {qy[COORD_BITS-1], qy};

  assign up_a = (rd_y >= qy) && (qy > y1);
  assign up_b = (rd_y > qy) && (qy >= y1);
  assign dn_a = (rd_y <= qy) && (qy < y1);
  assign dn_b = (rd_y < qy) && (qy <= y1);

  // Stage D: hold the edge start, form the differences and crossing flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else begin
      d_valid <= ctl.valid && ctl.is_edge;
    end
    if (ctl.valid) begin
      x1 <= rd_x;
      y1 <= rd_y;
    end
    d_dx  <= x2e - x1e;
    d_dyq <= qye - y1e;
    d_dy  <= y2e - y1e;
    d_dxq <= qxe - x1e;
    d_up  <= {1'b0, up_a} + {1'b0, up_b};
    d_dn  <= {1'b0, dn_a} + {1'b0, dn_b};
  end

  // Stage M: both cross-product terms.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= d_valid;
    end
    m_p1 <= d_dx * d_dyq;
    m_p2 <= d_dy * d_dxq;
    m_up <= d_up;
    m_dn <= d_dn;
  end

  assign up_ext = {{(ACC_W-2){1'b0}}, m_up};
  assign dn_ext = {{(ACC_W-2){1'b0}}, m_dn};

  // Stage S: sign of the cross product picks the counter to advance.
  always_ff @(posedge clk) begin
    if (rst || ctl.acc_clr) begin
      half_sum    <= '0;
      quarter_sum <= '0;
    end else if (m_valid) begin
      if (m_p1 > m_p2) begin
        half_sum <= half_sum + up_ext;
      end else if (m_p1 < m_p2) begin
        half_sum <= half_sum - dn_ext;
      end else begin
        quarter_sum <= quarter_sum + up_ext - dn_ext;
      end
    end
  end

endmodule

@@ src/polygon_winding_number_query.sv @@
// Top level of the polygon winding-number query block: sequencer, vertex count,
// result skid and output register. Depends on pwn_pkg, pwn_vstore and pwn_edge.
`timescale 1ns / 1ps

// Usage:
//   Input items arrive on s_tvalid/s_tready; s_tuser selects the action
//   (clear, append vertex, query) and s_tdata carries the vertex and query
//   coordinates. Every item yields exactly one result item on
//   m_tvalid/m_tready: a status code on m_tuser, the winding count and the
//   number of stored vertices on m_tdata.
//   Clear and append finish in the accept cycle; their result passes through
//   the skid register to the output register.
//   A query walks the stored polygon one edge per cycle: n + 1 memory reads
//   (the closing edge's start vertex first), then the drain state empties the
//   edge pipeline and the finish state forms the count; the memory read port
//   sets that rate.
//   One item is in work at a time. A finished result waits in a skid
//   register, so a new item is taken while the output register is stalled;
//   the next one after that waits until the skid empties.
//   Reset empties the polygon and drops any pending result. The vertex store
//   itself is not cleared; only entries below the count are ever read.
module polygon_winding_number_query
  import pwn_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 24
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // vertex_x, vertex_y, query_x, query_y (lowest bits first), zero padded
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]     s_tdata,
  // action
  input  logic [1:0]                            s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // winding (8 bits), vertex_count (lowest bits first), zero padded
  output logic [((8+$clog2(MAX_VERTICES+1)+7)/8)*8-1:0] m_tdata,
  // status
  output logic [1:0]                            m_tuser
);

  localparam int ADDR_W  = $clog2(MAX_VERTICES);
  localparam int CNT_W   = $clog2(MAX_VERTICES + 1);
  localparam int ACC_W   = ADDR_W + 3;
  localparam int EXT_W   = ACC_W + 8;
  localparam int OUT_W   = ((8 + CNT_W + 7) / 8) * 8;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic signed [EXT_W-1:0] W_MAX = EXT_W'(127);
  localparam logic signed [EXT_W-1:0] W_MIN = -EXT_W'(128);

  // input fields
  logic signed [COORD_BITS-1:0] vertex_x, vertex_y, query_x, query_y;
  assign vertex_x = s_tdata[COORD_BITS-1:0];
  assign vertex_y = s_tdata[2*COORD_BITS-1:COORD_BITS];
  assign query_x  = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
  assign query_y  = s_tdata[4*COORD_BITS-1:3*COORD_BITS];

  pwn_state_t state, state_next;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] walk_idx;
  logic [1:0]       drain_cnt;
  logic signed [COORD_BITS-1:0] qx, qy;

  logic accept;
  logic wr_en;
  logic rd_en;
  logic [CNT_W-1:0] rd_sel;
  logic signed [COORD_BITS-1:0] rd_x, rd_y;

  logic      tag_valid, tag_edge;
  logic      acc_clr;
  edge_ctl_t ctl;

  logic signed [ACC_W-1:0] half_sum, quarter_sum;

  // result skid and output register
  logic             res_valid;
  logic [1:0]       res_status;
  logic [7:0]       res_winding;
  logic [CNT_W-1:0] res_count;
  logic [7:0]       out_winding;
  logic [CNT_W-1:0] out_count;

  assign s_tready = (state == ST_IDLE) && !res_valid;
  assign accept   = s_tvalid && s_tready;
  assign wr_en    = accept && (s_tuser == ACT_APPEND) && (count < CNT_MAX);
  assign rd_en    = (state == ST_WALK);
  // first read fetches the last vertex: start of the closing edge
  assign rd_sel   = (walk_idx == '0) ? count - CNT_ONE : walk_idx - CNT_ONE;
  assign acc_clr  = accept;

  assign ctl.acc_clr = acc_clr;
  assign ctl.valid   = tag_valid;
  assign ctl.is_edge = tag_edge;

  pwn_vstore #(
    .COORD_BITS  (COORD_BITS),
    .MAX_VERTICES(MAX_VERTICES)
  ) u_vstore (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(count[ADDR_W-1:0]),
    .wr_x   (vertex_x),
    .wr_y   (vertex_y),
    .rd_en  (rd_en),
    .rd_addr(rd_sel[ADDR_W-1:0]),
    .rd_x   (rd_x),
    .rd_y   (rd_y)
  );

  pwn_edge #(
    .COORD_BITS  (COORD_BITS),
    .MAX_VERTICES(MAX_VERTICES)
  ) u_edge (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .qx         (qx),
    .qy         (qy),
    .rd_x       (rd_x),
    .rd_y       (rd_y),
    .half_sum   (half_sum),
    .quarter_sum(quarter_sum)
  );

  // Winding = half/2 + quarter/4, both truncated toward zero, then saturated.
  logic signed [EXT_W-1:0] h_ext, q_ext, h_adj, q_adj, h_div, q_div, w_sum;
  logic [7:0] w_sat;

  always_comb begin
    h_ext = EXT_W'(half_sum);
    q_ext = EXT_W'(quarter_sum);
    h_adj = h_ext + {{(EXT_W-1){1'b0}}, h_ext[EXT_W-1]};
    q_adj = q_ext + {{(EXT_W-2){1'b0}}, {2{q_ext[EXT_W-1]}}};
    h_div = h_adj >>> 1;
    q_div = q_adj >>> 2;
    w_sum = h_div + q_div;
    if (w_sum > W_MAX) begin
      w_sat = W_MAX[7:0];
    end else if (w_sum < W_MIN) begin
      w_sat = W_MIN[7:0];
    end else begin
      w_sat = w_sum[7:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && s_tuser[1] && (count != '0)) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_idx == count) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_cnt == '0) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      walk_idx  <= '0;
      drain_cnt <= '0;
      tag_valid <= 1'b0;
      tag_edge  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      // tag follows the read by the memory latency
      tag_valid <= rd_en;
      tag_edge  <= (walk_idx != '0);

      if (accept) begin
        walk_idx <= '0;
        unique case (s_tuser) inside
          ACT_CLEAR: begin
            count     <= '0;
            res_valid <= 1'b1;
          end
          ACT_APPEND: begin
            if (count < CNT_MAX) begin
              count <= count + CNT_ONE;
            end
            res_valid <= 1'b1;
          end
          ACT_QUERY, ACT_QUERY_ALT: begin
            // empty polygon answers at once
            if (count == '0) begin
              res_valid <= 1'b1;
            end
          end
          default: begin
            res_valid <= 1'b0;
          end
        endcase
      end else begin
        if (state == ST_WALK) begin
          walk_idx <= walk_idx + CNT_ONE;
        end
        if (state == ST_FINISH) begin
          res_valid <= 1'b1;
        end else if (res_valid && (!m_tvalid || m_tready)) begin
          res_valid <= 1'b0;
        end
      end

      if (state == ST_WALK) begin
        drain_cnt <= 2'd2;
      end else if (state == ST_DRAIN) begin
        drain_cnt <= drain_cnt - 2'd1;
      end
    end
  end

  // Result payload: set on accept for immediate answers, on finish for walks.
  always_ff @(posedge clk) begin
    if (accept) begin
      qx <= query_x;
      qy <= query_y;
      unique case (s_tuser) inside
        ACT_CLEAR: begin
          res_status  <= STAT_CLEARED;
          res_winding <= '0;
          res_count   <= '0;
        end
        ACT_APPEND: begin
          res_winding <= '0;
          if (count < CNT_MAX) begin
            res_status <= STAT_STORED;
            res_count  <= count + CNT_ONE;
          end else begin
            res_status <= STAT_DROPPED;
            res_count  <= count;
          end
        end
        ACT_QUERY, ACT_QUERY_ALT: begin
          res_status  <= STAT_ANSWER;
          res_winding <= '0;
          res_count   <= count;
        end
        default: begin
          res_status <= STAT_ANSWER;
        end
      endcase
    end else if (state == ST_FINISH) begin
      res_winding <= w_sat;
    end
  end

  // Output register: advance from the skid whenever the slot is free or taken, except in the finish state.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && (!m_tvalid || m_tready) && (state != ST_FINISH)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && (!m_tvalid || m_tready) && (state != ST_FINISH)) begin
      m_tuser     <= res_status;
      out_winding <= res_winding;
      out_count   <= res_count;
    end
  end

  assign m_tdata = OUT_W'({out_count, out_winding});

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for polygon_winding_number_query: directed and random
// polygons, vertex appends past a full store and winding queries. Depends on pwn_pkg and the RTL.
`timescale 1ns / 1ps

localparam int POLY_MAX = 64;

// Track the polygon, work out the expected result of every accepted item and
// compare it with what leaves the block, oldest first.
class winding_scoreboard;
  typedef struct {
    logic [1:0]        status;
    logic signed [7:0] winding;
    logic [6:0]        count;
  } result_t;

  longint  vx_mem[POLY_MAX];
  longint  vy_mem[POLY_MAX];
  int      nverts;
  int      errors;
  result_t expected_q[$];

  function new();
    nverts = 0;
    errors = 0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Winding count of (qx, qy): half steps for edges off the point's line,
  // quarter steps for edges whose line runs through it; closing edge first.
  function int winding_at(longint qx, longint qy);
    int     half;
    int     quarter;
    int     up;
    int     dn;
    int     w;
    int     prev;
    longint x1, y1, x2, y2, cr;
    half = 0;
    quarter = 0;
    if (nverts == 0) return 0;
    for (int k = 0; k < nverts; k++) begin
      prev = (k == 0) ? nverts - 1 : k - 1;
      x1 = vx_mem[prev];
      y1 = vy_mem[prev];
      x2 = vx_mem[k];
      y2 = vy_mem[k];
      // 24-bit coordinates keep the cross product well inside 64 bits
      cr = (x2 - x1) * (qy - y1) - (y2 - y1) * (qx - x1);
      up = int'(y2 >= qy && qy > y1) + int'(y2 > qy && qy >= y1);
      dn = int'(y2 <= qy && qy < y1) + int'(y2 < qy && qy <= y1);
      if (cr > 0) half += up;
      else if (cr < 0) half -= dn;
      else quarter += up - dn;
    end
    w = half / 2 + quarter / 4;
    if (w > 127) w = 127;
    if (w < -128) w = -128;
    return w;
  endfunction

  function void note_input(logic [1:0] act, logic signed [23:0] vx, logic signed [23:0] vy,
                           logic signed [23:0] qx, logic signed [23:0] qy);
    result_t r;
    r.winding = '0;
    if (act[1]) begin
      // both upper codes answer a query
      r.status  = pwn_pkg::STAT_ANSWER;
      r.winding = 8'(winding_at(longint'(qx), longint'(qy)));
    end else if (act == pwn_pkg::ACT_APPEND) begin
      if (nverts < POLY_MAX) begin
        vx_mem[nverts] = longint'(vx);
        vy_mem[nverts] = longint'(vy);
        nverts++;
        r.status = pwn_pkg::STAT_STORED;
      end else begin
        r.status = pwn_pkg::STAT_DROPPED;
      end
    end else begin
      nverts = 0;
      r.status = pwn_pkg::STAT_CLEARED;
    end
    r.count = 7'(nverts);
    expected_q.insert(expected_q.size(), r);
  endfunction

  function void check_result(logic [1:0] status, logic signed [7:0] winding, logic [6:0] count);
    result_t e;
    if (expected_q.size() == 0) begin
      $error("unexpected result: status %0d winding %0d count %0d", status, winding, count);
      errors++;
      return;
    end
    e = expected_q[0];
    expected_q.delete(0);
    if (status !== e.status) begin
      $error("status: expected %0d, actual %0d", e.status, status);
      errors++;
    end
    if (winding !== e.winding) begin
      $error("winding: expected %0d, actual %0d", e.winding, winding);
      errors++;
    end
    if (count !== e.count) begin
      $error("vertex_count: expected %0d, actual %0d", e.count, count);
      errors++;
    end
  endfunction
endclass

module tb;
  import pwn_pkg::*;

  localparam int CRD        = 24;
  localparam int N_ITEMS    = 1050;
  localparam int DRAIN_WAIT = 100;      // longer than a full-polygon query
  localparam int LIMIT      = 600000;   // cycles; far above the slowest legal run
  localparam longint CMAX   = 8388607;
  localparam longint CMIN   = -8388608;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata  = '0;   // vertex_x, vertex_y, query_x, query_y
  logic [1:0]  s_tuser  = '0;   // action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;         // winding, vertex_count, one pad bit
  logic [1:0]  m_tuser;         // status

  winding_scoreboard sb = new();

  int items_sent = 0;
  int burst_left = 0;
  int cycles     = 0;
  int rx_phase   = 0;
  int rx_mode    = 0;

  polygon_winding_number_query #(
    .MAX_VERTICES(POLY_MAX),
    .COORD_BITS  (CRD)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always #5 clk = ~clk;

  // Run guard: end the run if the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Input monitor: every accepted item adds one expected result.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      sb.note_input(s_tuser, s_tdata[23:0], s_tdata[47:24], s_tdata[71:48], s_tdata[95:72]);
  end

  // Output monitor: every accepted result is checked against the oldest one.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tuser, m_tdata[7:0], m_tdata[14:8]);
  end

  // Receiver: switch between always ready, coin-flip, long stalls and a
  // periodic stall pattern so stalls land on every phase of a query.
  always @(posedge clk) begin
    rx_phase <= rx_phase + 1;
    if (rx_phase % 256 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= 1'($urandom_range(0, 1));
      2:       m_tready <= ($urandom_range(0, 7) == 0);
      default: m_tready <= (rx_phase % 16) < 11;
    endcase
  end

  function automatic logic signed [23:0] rnd24();
    logic [31:0] r;
    r = $urandom();
    return r[23:0];
  endfunction

  function automatic logic signed [23:0] clip24(longint v);
    if (v > CMAX) return 24'(CMAX);
    if (v < CMIN) return 24'(CMIN);
    return 24'(v);
  endfunction

  // Random offset in [-span, span]; span stays below 2^31.
  function automatic longint jitter(longint span);
    return longint'($urandom_range(0, 32'(2 * span))) - span;
  endfunction

  // Present one item and hold it until accepted. The sender runs in bursts;
  // between bursts drop tvalid for a short random gap.
  task automatic send_item(logic [1:0] act, logic signed [23:0] vx, logic signed [23:0] vy,
                           logic signed [23:0] qx, logic signed [23:0] qy);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      // now and then a long stretch with no gaps
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {qy, qx, vy, vx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // Vertex and query items; the unused fields carry random noise.
  task automatic add_vertex(longint x, longint y);
    send_item(ACT_APPEND, clip24(x), clip24(y), rnd24(), rnd24());
  endtask

  task automatic ask_point(longint x, longint y);
    send_item(($urandom_range(0, 3) == 0) ? ACT_QUERY_ALT : ACT_QUERY,
              rnd24(), rnd24(), clip24(x), clip24(y));
  endtask

  task automatic wipe();
    send_item(ACT_CLEAR, rnd24(), rnd24(), rnd24(), rnd24());
  endtask

  // Hold the sender until the block has returned every pending result.
  task automatic drain_all();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // One random scene: optional clear, a polygon of some kind, then queries
  // aimed at its vertices, edges, interior and far away.
  task automatic random_scene();
    longint px[$];
    longint py[$];
    longint cx, cy, span, r;
    int     kind, n, turns, nq, pick, j;
    bit     ccw;
    px = {};
    py = {};
    span = 0;
    case ($urandom_range(0, 3))
      0:       span = 4;
      1:       span = 64;
      2:       span = 100000;
      default: span = CMAX;
    endcase
    cx = (span == CMAX) ? 0 : longint'(rnd24());
    cy = (span == CMAX) ? 0 : longint'(rnd24());
    if ($urandom_range(0, 9) != 0) wipe();
    kind = $urandom_range(0, 19);
    if (kind < 10) begin
      // scattered points in a box, including empty and single-vertex shapes
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
      repeat (n) begin
        px.insert(px.size(), longint'(clip24(cx + jitter(span))));
        py.insert(py.size(), longint'(clip24(cy + jitter(span))));
      end
    end else if (kind < 15) begin
      // square traced several times: winding of the inner points is +/- turns
      turns = $urandom_range(1, 6);
      ccw   = 1'($urandom_range(0, 1));
      r     = 1 + longint'($urandom_range(0, 32'(span)));
      repeat (turns) begin
        for (int c = 0; c < 4; c++) begin
          j = ccw ? c : 3 - c;
          px.insert(px.size(), longint'(clip24(cx + ((j == 0 || j == 3) ? r : -r))));
          py.insert(py.size(), longint'(clip24(cy + ((j < 2) ? r : -r))));
        end
      end
    end else if (kind < 17) begin
      // points on one line, with repeats: every edge is degenerate or collinear
      n = $urandom_range(2, 6);
      r = 1 + longint'($urandom_range(0, 3));
      pick = $urandom_range(0, 2);
      repeat (n) begin
        j = $urandom_range(0, 4);
        px.insert(px.size(), longint'(clip24(cx + j * r)));
        py.insert(py.size(), longint'(clip24(cy + j * r * pick)));
      end
    end else if (kind < 19) begin
      n = $urandom_range(3, 8);
      repeat (n) begin
        px.insert(px.size(), longint'(rnd24()));
        py.insert(py.size(), longint'(rnd24()));
      end
    end else begin
      // overfill: appends past the last slot are dropped
      n = $urandom_range(60, 70);
      repeat (n) begin
        px.insert(px.size(), longint'(clip24(cx + jitter(span))));
        py.insert(py.size(), longint'(clip24(cy + jitter(span))));
      end
    end
    foreach (px[i]) add_vertex(px[i], py[i]);
    nq = $urandom_range(2, 8);
    repeat (nq) begin
      pick = (px.size() == 0) ? 2 : $urandom_range(0, 5);
      j = (px.size() == 0) ? 0 : $urandom_range(0, px.size() - 1);
      case (pick)
        0: ask_point(px[j], py[j]);
        1: ask_point(px[j] + jitter(1), py[j] + jitter(1));
        2: ask_point(cx + jitter(span), cy + jitter(span));
        3: ask_point(rnd24(), rnd24());
        4: ask_point(cx + jitter(1), cy + jitter(1));
        default: ask_point((px[j] + px[(j + 1) % px.size()]) / 2,
                           (py[j] + py[(j + 1) % py.size()]) / 2);
      endcase
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty polygon, single vertex, 10-by-10 square with its interior,
    // edges, corners and outside, the alternate query code, then extremes.
    wipe();
    ask_point(0, 0);
    add_vertex(0, 0);
    ask_point(0, 0);
    ask_point(5, 5);
    add_vertex(10, 0);
    add_vertex(10, 10);
    add_vertex(0, 10);
    ask_point(5, 5);
    ask_point(10, 5);
    ask_point(5, 0);
    ask_point(0, 0);
    ask_point(10, 10);
    ask_point(20, 5);
    send_item(ACT_QUERY_ALT, rnd24(), rnd24(), 24'sd5, 24'sd5);
    wipe();
    add_vertex(CMIN, CMIN);
    add_vertex(CMAX, CMIN);
    add_vertex(CMAX, CMAX);
    add_vertex(CMIN, CMAX);
    ask_point(0, 0);
    ask_point(CMIN, CMAX);
    ask_point(CMAX, 0);
    ask_point(-1, -1);
    // Hold off until the block is empty once.
    drain_all();

    while (items_sent < N_ITEMS) begin
      if ($urandom_range(0, 14) == 0)
        send_item(2'($urandom_range(0, 3)), rnd24(), rnd24(), rnd24(), rnd24());
      random_scene();
      if ($urandom_range(0, 19) == 0) drain_all();
    end

    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end
endmodule
